// File: src/sas_pkg.sv
// Shared types, constants and arithmetic helpers for the stereo amp simulator.
package sas_pkg;

    // Sample and register widths.
    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 16;
    localparam int RATE_W   = 18;
    localparam int CFG_AW   = 3;
    localparam int COEF_W   = 27;
    localparam int NUM_W    = 45;
    localparam int BANDS    = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_AW-1:0] REG_DRIVE    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BASS     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MID      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TREBLE   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PRESENCE = 3'd4;
    localparam logic [CFG_AW-1:0] REG_MIX      = 3'd5;
    localparam logic [CFG_AW-1:0] REG_RATE     = 3'd6;

    // Fixed-point constants.
    localparam longint TWO_PI_Q28   = 64'd1686629711;
    localparam longint EIGHT_Q24    = 64'd13421773;
    localparam longint ONE_Q30      = 64'd1073741824;
    localparam logic [COEF_W-1:0] COEF_SAT = COEF_W'((TWO_PI_Q28 * 49 + 800) / 1600);

    // Divider numerators 2*pi*f in Q.28 and the limits 100*f for each band.
    localparam logic [NUM_W-1:0] BAND_NUM [BANDS] = '{
        NUM_W'(TWO_PI_Q28 * 150), NUM_W'(TWO_PI_Q28 * 1000),
        NUM_W'(TWO_PI_Q28 * 4000), NUM_W'(TWO_PI_Q28 * 8000)};
    localparam logic [23:0] BAND_LIM [BANDS] = '{
        24'(100 * 150), 24'(100 * 1000), 24'(100 * 4000), 24'(100 * 8000)};

    // Tanh table over 0..8 with one extra end entry, Q.24.
    localparam int TANH_N    = 256;
    localparam int TANH_LOG2 = $clog2(TANH_N);
    typedef logic [24:0] t_tanh_rom [0:TANH_N];

    typedef logic [COEF_W-1:0] t_coef_arr [BANDS];

    // Configuration register set.
    typedef struct packed {
        logic [LEVEL_W-1:0] drive;
        logic [LEVEL_W-1:0] bass;
        logic [LEVEL_W-1:0] mid;
        logic [LEVEL_W-1:0] treble;
        logic [LEVEL_W-1:0] presence;
        logic [LEVEL_W-1:0] mix;
        logic [RATE_W-1:0]  rate;
    } t_cfg;

    // Band state memory request.
    typedef struct packed {
        logic        we;
        logic [2:0]  addr;
        logic [31:0] wdata;
    } t_mem_req;

    // Channel sequencer states.
    typedef enum logic [4:0] {
        S_IDLE, S_COEF, S_DRV_MUL, S_DRV_SH, S_CLIP_IDX, S_CLIP_ROM, S_CLIP_MUL,
        S_CLIP_ADD, S_CLIP_NMUL, S_CLIP_NFIN, S_BAND_RD, S_BAND_DF, S_BAND_MC,
        S_BAND_UPD, S_BAND_MB, S_BAND_OUT, S_MIX_MA, S_MIX_MB, S_MIX_FIN,
        S_MIX_OUT, S_DONE
    } t_eng_state;

    // Unsigned shift-and-subtract division, used only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Builds the tanh table at elaboration: (1-e)/(1+e), e = exp(-2a).
    function automatic t_tanh_rom build_tanh_rom();
        t_tanh_rom      rom;
        longint unsigned y;
        longint unsigned z;
        longint unsigned term;
        longint unsigned v;
        longint unsigned e;
        longint         sum;
        for (int i = 0; i <= TANH_N; i++) begin
            y    = ((64'd16 << 30) * 64'(i)) >> TANH_LOG2;
            z    = y >> 8;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int k = 1; k <= 6; k++) begin
                term = udiv64((term * z) >> 30, 64'(k));
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = longint'(sum);
            for (int k = 0; k < 8; k++) begin
                v = (v * v + (ONE_Q30 >> 1)) >> 30;
            end
            e = v;
            if (e > ONE_Q30) begin
                e = ONE_Q30;
            end
            rom[i] = 25'(udiv64((ONE_Q30 - e) << 24, ONE_Q30 + e));
        end
        return rom;
    endfunction

    localparam t_tanh_rom TANH_ROM = build_tanh_rom();

    // Right shift that rounds half away from zero.
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned s);
        logic signed [63:0] h;
        h = 64'sd1 <<< (s - 1);
        if (v < 0) begin
            return (v + h - 64'sd1) >>> s;
        end
        return (v + h) >>> s;
    endfunction

    // Saturation to the signed 32-bit Q8.24 range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // Saturation to the output sample range.
    function automatic logic [SAMPLE_W-1:0] sat_out(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'h7fffff;
        end
        if (v < -64'sd8388608) begin
            return 24'h800000;
        end
        return SAMPLE_W'(v);
    endfunction

endpackage

// File: src/stereo_amp_simulator.sv
// Top level of the stereo amp simulator: registers, stream ports and output register.
//
//  Channel   Direction  Handshake                      Payload (low bits first)
//  s_axis    in         s_axis_tvalid/s_axis_tready    left_in[23:0], right_in[47:24]
//  m_axis    out        m_axis_tvalid/m_axis_tready    left_out[23:0], right_out[47:24]
//  cfg       in         i_cfg_wr_en                    i_cfg_addr, i_cfg_wdata
//
// From one accept to the next a pair passes 34 shared-multiplier steps per channel, two more
// for a channel whose driven value is not positive, plus a coefficient check and a result
// handoff, which can both wait, and an idle state. The result is valid in the handoff state.
// After reset and after each sample rate write the coefficient unit reruns its divides.
// Band states reset through valid bits, so no clearing pass is needed.
// A finished pair waits in the output register while the next pair is accepted.
module stereo_amp_simulator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [sas_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [sas_pkg::RATE_W-1:0]       i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [2*sas_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // left_in, right_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [2*sas_pkg::SAMPLE_W-1:0]   m_axis_tdata   // left_out, right_out
);

    sas_pkg::t_cfg                r_cfg;
    logic                         r_out_valid;
    logic [sas_pkg::SAMPLE_W-1:0] r_out_l;
    logic [sas_pkg::SAMPLE_W-1:0] r_out_r;

    logic                         eng_ready;
    logic                         eng_res_valid;
    logic                         res_take;
    logic [sas_pkg::SAMPLE_W-1:0] res_l;
    logic [sas_pkg::SAMPLE_W-1:0] res_r;
    logic                         coef_valid;
    sas_pkg::t_coef_arr           coef;
    sas_pkg::t_mem_req            mem_req;
    logic [31:0]                  mem_rdata;
    logic                         rate_wr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive    <= 16'd32768;
            r_cfg.bass     <= 16'd32768;
            r_cfg.mid      <= 16'd32768;
            r_cfg.treble   <= 16'd32768;
            r_cfg.presence <= 16'd32768;
            r_cfg.mix      <= 16'd65535;
            r_cfg.rate     <= 18'd48000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                sas_pkg::REG_DRIVE:    r_cfg.drive    <= i_cfg_wdata[15:0];
                sas_pkg::REG_BASS:     r_cfg.bass     <= i_cfg_wdata[15:0];
                sas_pkg::REG_MID:      r_cfg.mid      <= i_cfg_wdata[15:0];
                sas_pkg::REG_TREBLE:   r_cfg.treble   <= i_cfg_wdata[15:0];
                sas_pkg::REG_PRESENCE: r_cfg.presence <= i_cfg_wdata[15:0];
                sas_pkg::REG_MIX:      r_cfg.mix      <= i_cfg_wdata[15:0];
                sas_pkg::REG_RATE:     r_cfg.rate     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign rate_wr = i_cfg_wr_en && (i_cfg_addr == sas_pkg::REG_RATE);

    // Output register: loads when empty or being drained.
    assign res_take = eng_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_l <= res_l;
            r_out_r <= res_r;
        end
    end

    sas_coef_div u_coef (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_invalidate (rate_wr),
        .i_rate       (r_cfg.rate),
        .o_valid      (coef_valid),
        .o_coef       (coef)
    );

    sas_band_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    sas_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (s_axis_tvalid && eng_ready),
        .i_left       (s_axis_tdata[sas_pkg::SAMPLE_W-1:0]),
        .i_right      (s_axis_tdata[2*sas_pkg::SAMPLE_W-1:sas_pkg::SAMPLE_W]),
        .i_cfg        (r_cfg),
        .i_coef       (coef),
        .i_coef_valid (coef_valid),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata),
        .o_ready      (eng_ready),
        .o_res_valid  (eng_res_valid),
        .i_res_take   (res_take),
        .o_res_left   (res_l),
        .o_res_right  (res_r)
    );

    assign s_axis_tready = eng_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_l};

endmodule

// File: src/sas_band_mem.sv
// Band state memory: eight Q8.24 filter states with per-entry valid bits.
module sas_band_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sas_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [8];
    logic [7:0]  r_valid;
    logic [31:0] r_rdata;

    // Storage and registered read; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_valid[i_req.addr] ? r_mem[i_req.addr] : 32'd0;
    end

    // Valid bits stand in for clearing the states at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sas_coef_div.sv
// Band coefficient unit: one restoring divide per unclamped band, rerun after each rate write.
module sas_coef_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_invalidate,
    input  logic [sas_pkg::RATE_W-1:0]    i_rate,
    output logic                          o_valid,
    output sas_pkg::t_coef_arr            o_coef
);

    logic                            r_valid;
    logic                            r_busy;
    logic                            r_run;
    logic [1:0]                      r_band;
    logic [5:0]                      r_cnt;
    logic [21:0]                     r_rem;
    logic [sas_pkg::NUM_W-1:0]       r_num;
    sas_pkg::t_coef_arr              r_coef;

    logic [21:0] den;
    logic [22:0] rem_sh;
    logic        qbit;
    logic [21:0] rem_nx;
    logic        band_sat;

    // One quotient bit per cycle.
    always_comb begin
        den      = {i_rate, 4'b0000};
        rem_sh   = {r_rem, r_num[sas_pkg::NUM_W-1]};
        qbit     = (rem_sh >= {1'b0, den});
        rem_nx   = qbit ? 22'(rem_sh - {1'b0, den}) : 22'(rem_sh);
        band_sat = sas_pkg::BAND_LIM[r_band] >= 24'(i_rate) * 24'd49;
    end

    // Sequence over the four bands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_run   <= 1'b0;
            r_band  <= 2'd0;
            r_cnt   <= 6'd0;
        end else if (i_invalidate) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_run   <= 1'b0;
        end else if (!r_valid && !r_busy) begin
            r_busy <= 1'b1;
            r_band <= 2'd0;
        end else if (r_busy && !r_run) begin
            if (band_sat) begin
                r_band <= r_band + 2'd1;
                if (r_band == 2'd3) begin
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
            end else begin
                r_run <= 1'b1;
                r_cnt <= 6'd0;
            end
        end else if (r_run) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(sas_pkg::NUM_W - 1)) begin
                r_run  <= 1'b0;
                r_band <= r_band + 2'd1;
                if (r_band == 2'd3) begin
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
            end
        end
    end

    // Divider datapath and coefficient store.
    always_ff @(posedge i_clk) begin
        if (r_busy && !r_run) begin
            r_rem <= 22'd0;
            r_num <= sas_pkg::BAND_NUM[r_band] + sas_pkg::NUM_W'({i_rate, 3'b000});
            if (band_sat) begin
                r_coef[r_band] <= sas_pkg::COEF_SAT;
            end
        end else if (r_run) begin
            r_rem <= rem_nx;
            r_num <= {r_num[sas_pkg::NUM_W-2:0], qbit};
            if (r_cnt == 6'(sas_pkg::NUM_W - 1)) begin
                r_coef[r_band] <= sas_pkg::COEF_W'({r_num[sas_pkg::NUM_W-2:0], qbit});
            end
        end
    end

    assign o_valid = r_valid;
    assign o_coef  = r_coef;

endmodule

// File: src/sas_engine.sv
// Channel sequencer: drive, soft clip, four bands and mix on one shared multiplier.
module sas_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sas_pkg::SAMPLE_W-1:0]   i_left,
    input  logic [sas_pkg::SAMPLE_W-1:0]   i_right,
    input  sas_pkg::t_cfg                  i_cfg,
    input  sas_pkg::t_coef_arr             i_coef,
    input  logic                           i_coef_valid,
    output sas_pkg::t_mem_req              o_mem_req,
    input  logic [31:0]                    i_mem_rdata,
    output logic                           o_ready,
    output logic                           o_res_valid,
    input  logic                           i_res_take,
    output logic [sas_pkg::SAMPLE_W-1:0]   o_res_left,
    output logic [sas_pkg::SAMPLE_W-1:0]   o_res_right
);

    sas_pkg::t_eng_state r_state;
    sas_pkg::t_eng_state n_state;

    logic                          r_ch;
    logic [1:0]                    r_band;
    logic [sas_pkg::SAMPLE_W-1:0]  r_left;
    logic [sas_pkg::SAMPLE_W-1:0]  r_right;
    logic signed [31:0]            r_x;
    logic signed [31:0]            r_s;
    logic [29:0]                   r_m;
    logic                          r_neg;
    logic [24:0]                   r_t0;
    logic [24:0]                   r_t;
    logic [26:0]                   r_frac;
    logic signed [33:0]            r_opa;
    logic signed [61:0]            r_prod;
    logic signed [61:0]            r_acc;
    logic signed [33:0]            r_v;
    logic [sas_pkg::SAMPLE_W-1:0]  r_res_l;
    logic [sas_pkg::SAMPLE_W-1:0]  r_res_r;

    logic signed [24:0] dry;
    logic [15:0]        lvl;
    logic [19:0]        drive_k;
    logic signed [33:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [61:0] mul_p;
    logic signed [33:0] x3;
    logic [7:0]         rom_idx;
    logic               rom_big;
    logic [24:0]        rom_t0;
    logic [24:0]        rom_t1;
    logic signed [31:0] s_new;
    logic [24:0]        t_sum;

    // Operand selection and helpers.
    always_comb begin
        dry     = r_ch ? signed'({r_right, 1'b0}) : signed'({r_left, 1'b0});
        case (r_band)
            2'd0:    lvl = i_cfg.bass;
            2'd1:    lvl = i_cfg.mid;
            2'd2:    lvl = i_cfg.treble;
            default: lvl = i_cfg.presence;
        endcase
        drive_k = 20'd65536 + 20'(i_cfg.drive) * 20'd9;
        x3      = 34'(r_x) + (34'(r_x) <<< 1);
        rom_idx = r_m[26:19];
        rom_big = |r_m[29:27];
        rom_t0  = rom_big ? sas_pkg::TANH_ROM[sas_pkg::TANH_N] : sas_pkg::TANH_ROM[{1'b0, rom_idx}];
        rom_t1  = sas_pkg::TANH_ROM[9'({1'b0, rom_idx}) + 9'd1];
        s_new   = sas_pkg::sat32(64'(r_s) + sas_pkg::rshr(64'(r_prod), 24));
        t_sum   = 25'({1'b0, r_t0} + 26'(sas_pkg::rshr(64'(r_prod), 27)));
        case (r_state)
            sas_pkg::S_DRV_MUL: begin
                mul_a = 34'(dry);
                mul_b = signed'({8'd0, drive_k});
            end
            sas_pkg::S_CLIP_MUL: begin
                mul_a = r_opa;
                mul_b = signed'({1'b0, r_frac});
            end
            sas_pkg::S_CLIP_NMUL: begin
                mul_a = signed'({9'd0, r_t});
                mul_b = 28'(sas_pkg::EIGHT_Q24);
            end
            sas_pkg::S_BAND_MC: begin
                mul_a = r_opa;
                mul_b = signed'({1'b0, i_coef[r_band]});
            end
            sas_pkg::S_BAND_UPD: begin
                mul_a = 34'(r_x);
                mul_b = signed'(28'(18'd65536 - 18'(lvl)));
            end
            sas_pkg::S_BAND_MB: begin
                mul_a = 34'(r_s);
                mul_b = signed'(28'({lvl, 1'b0}));
            end
            sas_pkg::S_MIX_MA: begin
                mul_a = 34'(dry);
                mul_b = signed'(28'(18'd65536 - 18'(i_cfg.mix)));
            end
            sas_pkg::S_MIX_MB: begin
                mul_a = 34'(r_x);
                mul_b = signed'(28'(i_cfg.mix));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sas_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and memory requests.
    always_comb begin
        n_state         = r_state;
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = {r_ch, r_band};
        o_mem_req.wdata = s_new;
        case (r_state)
            sas_pkg::S_IDLE:      if (i_start) n_state = sas_pkg::S_COEF;
            sas_pkg::S_COEF:      if (i_coef_valid) n_state = sas_pkg::S_DRV_MUL;
            sas_pkg::S_DRV_MUL:   n_state = sas_pkg::S_DRV_SH;
            sas_pkg::S_DRV_SH:    n_state = sas_pkg::S_CLIP_IDX;
            sas_pkg::S_CLIP_IDX:  n_state = sas_pkg::S_CLIP_ROM;
            sas_pkg::S_CLIP_ROM:  n_state = sas_pkg::S_CLIP_MUL;
            sas_pkg::S_CLIP_MUL:  n_state = sas_pkg::S_CLIP_ADD;
            sas_pkg::S_CLIP_ADD:  n_state = r_neg ? sas_pkg::S_CLIP_NMUL : sas_pkg::S_BAND_RD;
            sas_pkg::S_CLIP_NMUL: n_state = sas_pkg::S_CLIP_NFIN;
            sas_pkg::S_CLIP_NFIN: n_state = sas_pkg::S_BAND_RD;
            sas_pkg::S_BAND_RD:   n_state = sas_pkg::S_BAND_DF;
            sas_pkg::S_BAND_DF:   n_state = sas_pkg::S_BAND_MC;
            sas_pkg::S_BAND_MC:   n_state = sas_pkg::S_BAND_UPD;
            sas_pkg::S_BAND_UPD: begin
                o_mem_req.we = 1'b1;
                n_state      = sas_pkg::S_BAND_MB;
            end
            sas_pkg::S_BAND_MB:   n_state = sas_pkg::S_BAND_OUT;
            sas_pkg::S_BAND_OUT:  n_state = (r_band == 2'd3) ? sas_pkg::S_MIX_MA : sas_pkg::S_BAND_RD;
            sas_pkg::S_MIX_MA:    n_state = sas_pkg::S_MIX_MB;
            sas_pkg::S_MIX_MB:    n_state = sas_pkg::S_MIX_FIN;
            sas_pkg::S_MIX_FIN:   n_state = sas_pkg::S_MIX_OUT;
            sas_pkg::S_MIX_OUT:   n_state = r_ch ? sas_pkg::S_DONE : sas_pkg::S_DRV_MUL;
            sas_pkg::S_DONE:      if (i_res_take) n_state = sas_pkg::S_IDLE;
            default:              n_state = sas_pkg::S_IDLE;
        endcase
    end

    // Channel and band counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= 1'b0;
            r_band <= 2'd0;
        end else if (r_state == sas_pkg::S_IDLE) begin
            r_ch <= 1'b0;
        end else if (r_state == sas_pkg::S_DRV_MUL) begin
            r_band <= 2'd0;
        end else if (r_state == sas_pkg::S_BAND_OUT) begin
            r_band <= r_band + 2'd1;
        end else if (r_state == sas_pkg::S_MIX_OUT) begin
            r_ch <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            sas_pkg::S_IDLE: begin
                if (i_start) begin
                    r_left  <= i_left;
                    r_right <= i_right;
                end
            end
            sas_pkg::S_DRV_SH: r_x <= 32'(sas_pkg::rshr(64'(r_prod), 16));
            sas_pkg::S_CLIP_IDX: begin
                r_neg <= (r_x <= 0);
                r_m   <= (r_x > 0) ? 30'(x3 >>> 1) : 30'(-(34'(r_x) <<< 1));
            end
            sas_pkg::S_CLIP_ROM: begin
                r_t0   <= rom_t0;
                r_opa  <= rom_big ? 34'sd0 : signed'(34'(rom_t1 - rom_t0));
                r_frac <= {r_m[18:0], 8'd0};
            end
            sas_pkg::S_CLIP_ADD: begin
                r_t <= t_sum;
                r_x <= 32'(t_sum);
            end
            sas_pkg::S_CLIP_NFIN: r_x <= -32'(sas_pkg::rshr(64'(r_prod), 24));
            sas_pkg::S_BAND_DF: begin
                r_s   <= i_mem_rdata;
                r_opa <= 34'(r_x) - 34'(signed'(i_mem_rdata));
            end
            sas_pkg::S_BAND_UPD: r_s <= s_new;
            sas_pkg::S_BAND_MB:  r_acc <= r_prod;
            sas_pkg::S_BAND_OUT: r_x <= sas_pkg::sat32(
                                        sas_pkg::rshr(64'(r_acc) + 64'(r_prod), 16));
            sas_pkg::S_MIX_MB:   r_acc <= r_prod;
            sas_pkg::S_MIX_FIN:  r_v <= 34'(sas_pkg::rshr(64'(r_acc) + 64'(r_prod), 16));
            sas_pkg::S_MIX_OUT: begin
                if (r_ch) begin
                    r_res_r <= sas_pkg::sat_out(sas_pkg::rshr(64'(r_v), 1));
                end else begin
                    r_res_l <= sas_pkg::sat_out(sas_pkg::rshr(64'(r_v), 1));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready     = (r_state == sas_pkg::S_IDLE);
    assign o_res_valid = (r_state == sas_pkg::S_DONE);
    assign o_res_left  = r_res_l;
    assign o_res_right = r_res_r;

endmodule

// File: verif/sas_checker.sv
// Checker for the stereo amp simulator: tracks registers, predicts each output pair, compares.
`timescale 1ns / 1ps

module sas_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sas_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [sas_pkg::RATE_W-1:0]         i_cfg_wdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [2*sas_pkg::SAMPLE_W-1:0]     i_in_data,   // left_in, right_in
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [2*sas_pkg::SAMPLE_W-1:0]     i_out_data,  // left_out, right_out
    output int                                 o_pending,
    output int                                 o_errors
);
    import sas_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_pair;

    localparam longint TWO_PI = 64'd1686629711;
    localparam longint FOUR_FIFTHS = 64'd13421773;
    localparam longint Q30 = 64'd1073741824;

    t_pair         amp_expected [$];
    longint        tanh_tab [0:256];
    logic [15:0]   drive_lvl;
    logic [15:0]   band_lvl [0:3];
    logic [15:0]   mix_lvl;
    logic [17:0]   rate_hz;
    longint        tone_state [0:7];

    // Right shift of a product, rounded half away from zero.
    function automatic longint round_shift(input longint v, input int s);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Tanh in Q.24 from the interpolated table, argument nonnegative Q.24.
    function automatic longint tanh_q24(input longint m);
        longint pos;
        longint idx;
        longint frac;
        pos = m * 256;
        idx = pos >>> 27;
        frac = pos & ((64'sd1 <<< 27) - 1);
        if (idx >= 256) return tanh_tab[256];
        return tanh_tab[idx] + round_shift((tanh_tab[idx+1] - tanh_tab[idx]) * frac, 27);
    endfunction

    function automatic longint tone_coef(input longint f);
        longint fs;
        fs = longint'(rate_hz);
        if (100 * f >= 49 * fs) return (TWO_PI * 49 + 800) / 1600;
        return (TWO_PI * f + fs * 8) / (fs * 16);
    endfunction

    // One channel from input sample to saturated output sample.
    function automatic logic [SAMPLE_W-1:0] amp_channel(input logic [SAMPLE_W-1:0] raw,
                                                        input int ch);
        longint freqs [0:3];
        longint dry;
        longint x;
        longint c;
        longint s;
        longint lv;
        freqs = '{150, 1000, 4000, 8000};
        dry = longint'($signed(raw)) * 2;
        x = round_shift(dry * (65536 + 9 * longint'(drive_lvl)), 16);
        if (x > 0) x = tanh_q24((3 * x) >>> 1);
        else x = -round_shift(tanh_q24(-2 * x) * FOUR_FIFTHS, 24);
        for (int b = 0; b < 4; b++) begin
            c = tone_coef(freqs[b]);
            s = tone_state[ch*4 + b];
            lv = longint'(band_lvl[b]);
            s = clamp32(s + round_shift(c * (x - s), 24));
            tone_state[ch*4 + b] = s;
            x = clamp32(round_shift(x * (65536 - lv) + s * 2 * lv, 16));
        end
        x = round_shift(dry * (65536 - longint'(mix_lvl)) + x * longint'(mix_lvl), 16);
        x = round_shift(x, 1);
        if (x > 64'sd8388607) x = 64'sd8388607;
        if (x < -64'sd8388608) x = -64'sd8388608;
        return x[SAMPLE_W-1:0];
    endfunction

    // Tanh table: (1-e)/(1+e) with e = exp(-2a) from a short series, squared 8 times.
    initial begin
        longint unsigned y;
        longint unsigned z;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        for (int i = 0; i <= 256; i++) begin
            y = ((64'd16 << 30) * i) / 256;
            z = y >> 8;
            term = Q30;
            acc = Q30;
            for (int k = 1; k <= 6; k++) begin
                term = ((term * z) >> 30) / k;
                if (k % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            v = acc;
            for (int k = 0; k < 8; k++) v = (v * v + (Q30 >> 1)) >> 30;
            if (v > Q30) v = Q30;
            tanh_tab[i] = longint'(((Q30 - v) << 24) / (Q30 + v));
        end
    end

    assign o_pending = amp_expected.size();

    // Register tracking, prediction on each accepted request, comparison on each result.
    always @(posedge i_clk) begin
        t_pair want;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            drive_lvl <= 16'd32768;
            for (int b = 0; b < 4; b++) band_lvl[b] <= 16'd32768;
            mix_lvl <= 16'd65535;
            rate_hz <= 18'd48000;
            for (int i = 0; i < 8; i++) tone_state[i] = 0;
            amp_expected.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_DRIVE:    drive_lvl <= i_cfg_wdata[15:0];
                    REG_BASS:     band_lvl[0] <= i_cfg_wdata[15:0];
                    REG_MID:      band_lvl[1] <= i_cfg_wdata[15:0];
                    REG_TREBLE:   band_lvl[2] <= i_cfg_wdata[15:0];
                    REG_PRESENCE: band_lvl[3] <= i_cfg_wdata[15:0];
                    REG_MIX:      mix_lvl <= i_cfg_wdata[15:0];
                    REG_RATE:     rate_hz <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                want.left  = amp_channel(i_in_data[23:0], 0);
                want.right = amp_channel(i_in_data[47:24], 1);
                amp_expected.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (amp_expected.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    errs = errs + 1;
                end else begin
                    want = amp_expected.pop_front();
                    if (want.left !== i_out_data[23:0]) begin
                        $display("%0t: left_out expected %h actual %h", $time, want.left,
                                 i_out_data[23:0]);
                        errs = errs + 1;
                    end
                    if (want.right !== i_out_data[47:24]) begin
                        $display("%0t: right_out expected %h actual %h", $time, want.right,
                                 i_out_data[47:24]);
                        errs = errs + 1;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the stereo amp simulator: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_top;
    import sas_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_AW-1:0]       i_cfg_addr;
    logic [RATE_W-1:0]       i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [2*SAMPLE_W-1:0]   s_axis_tdata;   // left_in, right_in
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [2*SAMPLE_W-1:0]   m_axis_tdata;   // left_out, right_out
    int                      pending;
    int                      errors;
    int                      cycles = 0;
    logic                    gaps_on;

    stereo_amp_simulator dut (.*);

    sas_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 34);
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one sample pair and holds it until the request is taken.
    task automatic send_pair(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
        while (gaps_on && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // One register write, after which the write enable is dropped again before the task returns.
    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [RATE_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lets the block drain before registers change.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Random, mid-scale, small or full-scale values, each a quarter of the time.
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($signed($urandom_range(4000)) - 2000);
            2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
            default: return SAMPLE_W'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic random_pairs(input int n);
        for (int k = 0; k < n; k++) send_pair(rand_sample(), rand_sample());
    endtask

    task automatic set_all(input logic [RATE_W-1:0] drv, input logic [RATE_W-1:0] lvl,
                           input logic [RATE_W-1:0] mix, input logic [RATE_W-1:0] rate);
        write_reg(REG_DRIVE, drv);
        write_reg(REG_BASS, lvl);
        write_reg(REG_MID, lvl);
        write_reg(REG_TREBLE, lvl);
        write_reg(REG_PRESENCE, lvl);
        write_reg(REG_MIX, mix);
        write_reg(REG_RATE, rate);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        gaps_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero, tiny values and signs at reset settings.
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h7fffff, 24'h800000);
        send_pair(24'h800000, 24'h7fffff);
        send_pair(24'h000001, 24'hffffff);
        send_pair(24'hffffff, 24'h000001);
        send_pair(24'h400000, 24'hc00000);
        send_pair(24'h0aaaaa, 24'h155555);
        send_pair(24'h7fffff, 24'h7fffff);
        send_pair(24'h800000, 24'h800000);
        drain();

        // Zero drive and levels, dry only, rate at zero takes the coefficient clamp.
        set_all(18'd0, 18'd0, 18'd0, 18'd0);
        send_pair(24'h7fffff, 24'h800000);
        send_pair(24'h123456, 24'hedcba9);
        random_pairs(60);
        drain();

        // Everything at maximum with the lowest rate: coefficient clamp, unstable bands.
        set_all(18'h3ffff, 18'h3ffff, 18'h3ffff, 18'd8000);
        send_pair(24'h7fffff, 24'h800000);
        send_pair(24'h800000, 24'h7fffff);
        random_pairs(100);
        drain();

        // Highest rate with the largest register value, no gaps at either side.
        gaps_on <= 1'b0;
        set_all(18'd65535, 18'd32768, 18'd32768, 18'h3ffff);
        write_reg(3'd7, 18'h2aaaa);
        random_pairs(120);
        drain();
        gaps_on <= 1'b1;

        set_all(18'd1000, 18'd20000, 18'd40000, 18'd192000);
        random_pairs(100);
        drain();

        // Random register settings.
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_DRIVE, RATE_W'($urandom));
            write_reg(REG_BASS, RATE_W'($urandom));
            write_reg(REG_MID, RATE_W'($urandom));
            write_reg(REG_TREBLE, RATE_W'($urandom));
            write_reg(REG_PRESENCE, RATE_W'($urandom));
            write_reg(REG_MIX, RATE_W'($urandom));
            write_reg(REG_RATE, RATE_W'($urandom_range(192000, 8000)));
            random_pairs(80);
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
